// ===== rtl/max_min_gap_placement_unit_assert.svh =====
// assertion macros for the gap placement unit
`ifndef MAX_MIN_GAP_PLACEMENT_UNIT_ASSERT_SVH
`define MAX_MIN_GAP_PLACEMENT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MMGP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequence is checked in the following cycle
`define MMGP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/mmgp_pkg.sv =====
package mmgp_pkg;
	localparam int MaxPoints = 1024;
	localparam int PosBits = 20;
	localparam int CntBits = $clog2(MaxPoints + 1);
	localparam int CfgBits = 11;

	// control broadcast down the cell chain
	typedef struct packed {
		logic                insert;   // load one new point
		logic [PosBits-1:0]  pos;      // point being loaded
	} cell_ctl_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic                valid;    // a point is held to the left
		logic [PosBits-1:0]  value;    // that point
	} cell_link_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_INIT  = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;
endpackage

// ===== rtl/mmgp_cell.sv =====
// one sorting cell: keeps the larger points shifted to the right
module mmgp_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  mmgp_pkg::cell_ctl_t            ctl,
	input  mmgp_pkg::cell_link_t           left,
	output mmgp_pkg::cell_link_t           here
);
	logic                          valid_q;
	logic [mmgp_pkg::PosBits-1:0]  value_q;
	logic                          take_new;
	logic                          take_left;

	always_comb begin
		// new point goes here when this cell is empty or holds a larger point, and the left one is valid and not above it
		take_left = ctl.insert && left.valid && (left.value > ctl.pos);
		take_new  = ctl.insert && !take_left && left.valid &&
			(!valid_q || value_q > ctl.pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (take_left || take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			value_q <= left.value;
		end else if (take_new) begin
			value_q <= ctl.pos;
		end
	end

	assign here.valid = valid_q;
	assign here.value = value_q;
endmodule

// ===== rtl/mmgp_chain.sv =====
// row of sorting cells, read out by a shifting scan pointer
module mmgp_chain (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  mmgp_pkg::cell_ctl_t             ctl,
	input  logic [mmgp_pkg::CntBits-1:0]    rd_idx,
	output logic [mmgp_pkg::PosBits-1:0]    rd_data,
	output logic [mmgp_pkg::PosBits-1:0]    first_pt
);
	mmgp_pkg::cell_link_t link [mmgp_pkg::MaxPoints+1];
	logic [mmgp_pkg::PosBits-1:0] rd_q;

	// left end: the head cell always takes the new point when it is empty
	assign link[0].valid = 1'b1;
	assign link[0].value = '0;

	for (genvar g = 0; g < mmgp_pkg::MaxPoints; g++) begin : g_cell
		mmgp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (clear),
			.ctl    (ctl),
			.left   (link[g]),
			.here   (link[g+1])
		);
	end

	// registered read of one cell
	always_ff @(posedge clk) begin
		rd_q <= link[{1'b0, rd_idx[mmgp_pkg::CntBits-2:0]} + mmgp_pkg::CntBits'(1)].value;
	end

	assign rd_data  = rd_q;
	assign first_pt = link[1].value;
endmodule

// ===== rtl/max_min_gap_placement_unit.sv =====
// channel | role   | handshake             | payload
// in      | input  | in_valid in_ready     | position last
// out     | output | out_valid out_ready   | min_gap found
// cfg     | input  | cfg_valid cfg_ready   | cfg_data
//
// points load one per cycle into the sorting chain, ready stays high while loading but for a last item
// behind a held result; the last item starts a binary search: the span is read from the top cell, then up to PosBits
// probes, each a scan over the stored points through one read port
// the result waits in an output register while the chain is cleared for the next set;
// a held result stalls only the last item of the next set
// reset clears counts and the chain valid bits and sets the required count register to 2
module max_min_gap_placement_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [19:0]                     position,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [19:0]                     min_gap,
	output logic                            found,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [10:0]                     cfg_data
);
	`include "max_min_gap_placement_unit_assert.svh"

	localparam int PB = mmgp_pkg::PosBits;
	localparam int CB = mmgp_pkg::CntBits;

	mmgp_pkg::state_t state_q;
	mmgp_pkg::cell_ctl_t ctl;
	logic [CB-1:0]       count_q;
	logic [CB-1:0]       idx_q;       // next cell to read
	logic [CB-1:0]       placed_q;
	logic [mmgp_pkg::CfgBits-1:0] need_q;
	logic [PB:0]         low_q;
	logic [PB:0]         high_q;
	logic [PB-1:0]       mid_q;
	logic [PB-1:0]       best_q;
	logic [PB-1:0]       last_pl_q;
	logic                rd_vld_q;    // rd_data holds a point of this scan
	logic [PB-1:0]       rd_data;
	logic [PB-1:0]       first_pt;
	logic                accept;
	logic                full;
	logic                ok;
	logic                chain_clear;
	logic                zero_span;
	logic                search_end;
	logic                probe_start;
	logic                probe_done;
	logic [PB:0]         mid_calc;

	assign full     = (count_q == CB'(mmgp_pkg::MaxPoints));
	assign accept   = in_valid && in_ready;
	// the last item would overwrite the held result, so it waits for the handoff
	assign in_ready = (state_q == mmgp_pkg::ST_LOAD) && !(out_valid && last);
	assign cfg_ready = 1'b1;

	// search ends: either all points coincide or the bounds have crossed
	assign zero_span   = (state_q == mmgp_pkg::ST_INIT) && rd_vld_q && (rd_data == first_pt);
	assign search_end  = (state_q == mmgp_pkg::ST_SCAN) && (low_q > high_q);
	assign chain_clear = zero_span || search_end;

	// probe start: pointer back at the second point, nothing read yet
	assign probe_start = !rd_vld_q && (idx_q == CB'(1));
	// probe end: pointer past the top and the last read consumed
	assign probe_done  = !rd_vld_q && !(idx_q < count_q);

	always_comb begin
		ctl.insert   = accept && !full;
		ctl.pos      = position;
		mid_calc     = low_q + ((high_q - low_q) >> 1);
		ok           = ({1'b0, placed_q} >= {1'b0, need_q});
	end

	mmgp_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (chain_clear),
		.ctl      (ctl),
		.rd_idx   (idx_q),
		.rd_data  (rd_data),
		.first_pt (first_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mmgp_pkg::ST_LOAD;
			count_q   <= '0;
			need_q    <= 11'd2;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			low_q     <= '0;
			high_q    <= '0;
			mid_q     <= '0;
			best_q    <= '0;
			placed_q  <= '0;
			last_pl_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				need_q <= cfg_data;
			end
			case (state_q)
				mmgp_pkg::ST_LOAD: begin
					// result handoff, loading goes on meanwhile
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
					end
					if (accept) begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
						if (last) begin
							// read the top cell to get the span
							idx_q    <= full ? count_q - 1'b1 : count_q;
							rd_vld_q <= 1'b0;
							best_q   <= '0;
							state_q  <= mmgp_pkg::ST_INIT;
						end
					end
				end
				mmgp_pkg::ST_INIT: begin
					if (!rd_vld_q) begin
						rd_vld_q <= 1'b1;
					end else if (zero_span) begin
						rd_vld_q  <= 1'b0;
						out_valid <= 1'b1;
						count_q   <= '0;
						state_q   <= mmgp_pkg::ST_LOAD;
					end else begin
						low_q     <= (PB+1)'(1);
						high_q    <= {1'b0, rd_data - first_pt};
						rd_vld_q  <= 1'b0;
						idx_q     <= CB'(1);
						placed_q  <= CB'(1);
						last_pl_q <= first_pt;
						state_q   <= mmgp_pkg::ST_SCAN;
					end
				end
				mmgp_pkg::ST_SCAN: begin
					if (search_end) begin
						out_valid <= 1'b1;
						count_q   <= '0;
						state_q   <= mmgp_pkg::ST_LOAD;
					end else if (probe_done) begin
						if (ok) begin
							best_q <= mid_q;
							low_q  <= {1'b0, mid_q} + 1'b1;
						end else begin
							high_q <= {1'b0, mid_q} - 1'b1;
						end
						idx_q     <= CB'(1);
						placed_q  <= CB'(1);
						last_pl_q <= first_pt;
						rd_vld_q  <= 1'b0;
					end else begin
						// fresh midpoint after each bound change
						if (probe_start) begin
							mid_q <= PB'(mid_calc);
						end
						// one point a cycle through the read register
						if (idx_q < count_q) begin
							idx_q <= idx_q + 1'b1;
						end
						rd_vld_q <= (idx_q < count_q);
						if (rd_vld_q && (rd_data - last_pl_q >= mid_q)) begin
							placed_q  <= placed_q + 1'b1;
							last_pl_q <= rd_data;
						end
					end
				end
				default: begin
					state_q <= mmgp_pkg::ST_LOAD;
				end
			endcase
		end
	end

	assign min_gap = best_q;
	assign found   = (best_q != '0);

	`MMGP_ASSERT_IMPL(a_ready_load, in_ready, state_q == mmgp_pkg::ST_LOAD)
	`MMGP_ASSERT_IMPL(a_found_gap, out_valid && found, min_gap != '0)
	`MMGP_ASSERT_NEXT(a_out_drop, out_valid && out_ready, !out_valid)
endmodule
